// ===== hw/rtl/tta_pkg.sv =====
package tta_pkg;

   localparam int IDX_W      = 10;
   localparam int COORD_W    = 32;
   localparam int SUM_W      = 48;
   localparam int DELTA_W    = COORD_W + 1;
   localparam int PROD_W     = 2 * DELTA_W;
   localparam int WIDE_W     = PROD_W + 1;
   localparam int QUOT_W     = SUM_W;
   localparam int VERTEX_W   = 5 * COORD_W;
   localparam int SUMS_W     = 3 * SUM_W;
   localparam int REQ_DATA_W = 192;
   localparam int RSP_DATA_W = 144;

   localparam int DEFAULT_VERTEX_COUNT  = 1024;
   localparam int DEFAULT_FRACTION_BITS = 16;

   localparam logic [1:0] OP_LOAD     = 2'd0;
   localparam logic [1:0] OP_TRIANGLE = 2'd1;

   localparam logic [1:0] ST_LOADED  = 2'd0;
   localparam logic [1:0] ST_ADDED   = 2'd1;
   localparam logic [1:0] ST_SKIPPED = 2'd2;
   localparam logic [1:0] ST_READ    = 2'd3;

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_LOAD,
      S_RD_ISSUE,
      S_RD_CAPT,
      S_V0,
      S_V1,
      S_V2,
      S_V3,
      S_DELTA,
      S_MUL,
      S_DIFF,
      S_CHECK,
      S_DIV,
      S_ACC_RD,
      S_ACC_WR,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_CHECK,
      DIV_ITER,
      DIV_FINISH
   } div_state_type;

   typedef struct packed {
      logic start;
      logic done;
   } div_ctrl_type;

endpackage

// ===== hw/rtl/tta_ram.sv =====
module tta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/tta_div.sv =====
module tta_div #(
   parameter int FRACTION_BITS = tta_pkg::DEFAULT_FRACTION_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [tta_pkg::WIDE_W-1:0]  num,
   input  logic [tta_pkg::WIDE_W-1:0]  den,
   output logic                        done,
   output logic [tta_pkg::QUOT_W-1:0]  quotient
);

   import tta_pkg::*;

   localparam int NW    = WIDE_W + FRACTION_BITS;
   localparam int DW    = WIDE_W + QUOT_W;
   localparam int CW    = (NW > DW) ? NW : DW;
   localparam int RW    = WIDE_W + 1;
   localparam int CNT_W = $clog2(QUOT_W);

   div_state_type      state_ff, state_in;
   logic               neg_ff, neg_in;
   logic [WIDE_W-1:0]  nmag_ff, nmag_in;
   logic [WIDE_W-1:0]  dmag_ff, dmag_in;
   logic [RW-1:0]      rem_ff, rem_in;
   logic [QUOT_W-1:0]  low_ff, low_in;
   logic [QUOT_W-1:0]  q_ff, q_in;
   logic               ovf_ff, ovf_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   logic [NW-1:0]      n_full;
   logic [RW-1:0]      trial;
   logic               fits;
   logic [QUOT_W-1:0]  lim;
   logic [QUOT_W-1:0]  mag;

   assign n_full = {nmag_ff, {FRACTION_BITS{1'b0}}};
   assign trial  = {rem_ff[RW-2:0], low_ff[QUOT_W-1]};
   assign fits   = trial >= {1'b0, dmag_ff};

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         DIV_IDLE:   if (start) state_in = DIV_CHECK;
         DIV_CHECK:  state_in = DIV_ITER;
         DIV_ITER:   if (cnt_ff == CNT_W'(QUOT_W - 1)) state_in = DIV_FINISH;
         DIV_FINISH: state_in = DIV_IDLE;
         default:    state_in = DIV_IDLE;
      endcase
   end

   // Datapath updates per state.
   always_comb begin
      neg_in  = neg_ff;
      nmag_in = nmag_ff;
      dmag_in = dmag_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      q_in    = q_ff;
      ovf_in  = ovf_ff;
      cnt_in  = cnt_ff;
      case (state_ff)
         DIV_IDLE: begin
            if (start) begin
               neg_in  = num[WIDE_W-1] ^ den[WIDE_W-1];
               nmag_in = num[WIDE_W-1] ? (~num + 1'b1) : num;
               dmag_in = den[WIDE_W-1] ? (~den + 1'b1) : den;
            end
         end
         DIV_CHECK: begin
            // A quotient of 2^48 or more saturates, so only 48 quotient bits are formed.
            ovf_in = CW'(n_full) >= (CW'(dmag_ff) << QUOT_W);
            rem_in = RW'(n_full >> QUOT_W);
            low_in = n_full[QUOT_W-1:0];
            q_in   = '0;
            cnt_in = '0;
         end
         DIV_ITER: begin
            rem_in = fits ? (trial - {1'b0, dmag_ff}) : trial;
            q_in   = {q_ff[QUOT_W-2:0], fits};
            low_in = {low_ff[QUOT_W-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Outputs.
   always_comb begin
      lim      = neg_ff ? {1'b1, {(QUOT_W-1){1'b0}}} : {1'b0, {(QUOT_W-1){1'b1}}};
      mag      = (ovf_ff || (q_ff > lim)) ? lim : q_ff;
      quotient = neg_ff ? (~mag + 1'b1) : mag;
      done     = (state_ff == DIV_FINISH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
      neg_ff  <= neg_in;
      nmag_ff <= nmag_in;
      dmag_ff <= dmag_in;
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      q_ff    <= q_in;
      ovf_ff  <= ovf_in;
      cnt_ff  <= cnt_in;
   end

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> (state_ff == DIV_IDLE))
      else $error("divider started while busy");

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DIV_ITER && !ovf_ff) |-> (rem_ff < {1'b0, dmag_ff}))
      else $error("partial remainder not below divisor");

   a_finish_after_iter: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DIV_FINISH) |-> $past(state_ff == DIV_ITER))
      else $error("divider finished without iterating");

endmodule

// ===== hw/rtl/triangle_tangent_accumulator_core.sv =====
// Per-vertex tangent accumulator. Vertices (Q16.16 position and texture coordinate) and
// their 48-bit tangent sums live in two single-port-read block memories. After reset the
// block sweeps the sum memory to zero, one entry per cycle, and takes no beat until the
// sweep is done. A triangle takes 3 vertex reads, then deltas, products and differences,
// then the three parallel radix-2 dividers (48 quotient bits plus setup and finish steps),
// and a read-modify-write into the three corners' sums. One item is in flight at a time;
// the next beat is taken while a finished result waits in the output register.
module triangle_tangent_accumulator_core #(
   parameter int VERTEX_COUNT  = tta_pkg::DEFAULT_VERTEX_COUNT,
   parameter int FRACTION_BITS = tta_pkg::DEFAULT_FRACTION_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // first_index, second_index, third_index, pos_x, pos_y, pos_z, tex_u, tex_v
   input  logic [tta_pkg::REQ_DATA_W-1:0]   req_tdata,
   // opcode
   input  logic [1:0]                       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // tangent_x, tangent_y, tangent_z
   output logic [tta_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // status
   output logic [1:0]                       rsp_tuser
);

   import tta_pkg::*;

   localparam int AW = $clog2(VERTEX_COUNT);

   function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                input logic [SUM_W-1:0] b);
      logic [SUM_W:0] s;
      s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
      if (s[SUM_W] != s[SUM_W-1]) begin
         return s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end
      return s[SUM_W-1:0];
   endfunction

   function automatic logic in_range(input logic [IDX_W-1:0] idx);
      return 32'(idx) < 32'(VERTEX_COUNT);
   endfunction

   function automatic logic [DELTA_W-1:0] diff33(input logic [COORD_W-1:0] a,
                                                 input logic [COORD_W-1:0] b);
      return {a[COORD_W-1], a} - {b[COORD_W-1], b};
   endfunction

   state_type         state_ff, state_in;
   logic [AW-1:0]     clr_cnt_ff, clr_cnt_in;
   logic [1:0]        corner_ff, corner_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [1:0]        op_ff;
   logic [IDX_W-1:0]  idx_ff [3];
   logic              a_ok_ff;
   logic [VERTEX_W-1:0] load_ff;
   logic [VERTEX_W-1:0] va_ff, vb_ff, vc_ff;

   logic [DELTA_W-1:0] du1_ff, dv1_ff, du2_ff, dv2_ff;
   logic [DELTA_W-1:0] e1_ff [3];
   logic [DELTA_W-1:0] e2_ff [3];
   logic [PROD_W-1:0]  pdet_a_ff, pdet_b_ff;
   logic [PROD_W-1:0]  pn_a_ff [3];
   logic [PROD_W-1:0]  pn_b_ff [3];
   logic [WIDE_W-1:0]  det_ff;
   logic [WIDE_W-1:0]  num_ff [3];
   logic [SUM_W-1:0]   t_ff [3];

   logic [1:0]         res_status_ff;
   logic [SUMS_W-1:0]  res_sums_ff;
   logic [1:0]         rsp_status_ff;
   logic [SUMS_W-1:0]  rsp_sums_ff;

   logic               accept;
   logic               rsp_free;
   logic               vtx_we, vtx_re, sum_we, sum_re;
   logic [AW-1:0]      vtx_waddr, vtx_raddr, sum_waddr, sum_raddr;
   logic [SUMS_W-1:0]  sum_wdata;
   logic [VERTEX_W-1:0] vtx_rd_data;
   logic [SUMS_W-1:0]  sum_rd_data;
   logic               rsp_load;
   logic [AW-1:0]      corner_addr;
   logic [2:0]         div_done;
   logic [QUOT_W-1:0]  quot [3];
   div_ctrl_type       div_ctrl;

   logic [IDX_W-1:0]   in_first, in_second, in_third;

   assign in_first  = req_tdata[9:0];
   assign in_second = req_tdata[19:10];
   assign in_third  = req_tdata[29:20];

   assign accept      = req_tvalid && req_tready;
   assign rsp_free    = !rsp_valid_ff || rsp_tready;
   assign corner_addr = AW'(idx_ff[corner_ff]);
   assign div_ctrl.start = (state_ff == S_CHECK) && (det_ff != '0);
   assign div_ctrl.done  = div_done[0];

   // Next state.
   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      corner_in  = corner_ff;
      case (state_ff)
         S_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == AW'(VERTEX_COUNT - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == OP_LOAD) begin
                  state_in = S_LOAD;
               end else if (req_tuser == OP_TRIANGLE) begin
                  if (in_range(in_first) && in_range(in_second) && in_range(in_third)) begin
                     state_in = S_V0;
                  end else begin
                     state_in = S_DONE;
                  end
               end else begin
                  state_in = S_RD_ISSUE;
               end
            end
         end
         S_LOAD:     state_in = S_DONE;
         S_RD_ISSUE: state_in = S_RD_CAPT;
         S_RD_CAPT:  state_in = S_DONE;
         S_V0:       state_in = S_V1;
         S_V1:       state_in = S_V2;
         S_V2:       state_in = S_V3;
         S_V3:       state_in = S_DELTA;
         S_DELTA:    state_in = S_MUL;
         S_MUL:      state_in = S_DIFF;
         S_DIFF:     state_in = S_CHECK;
         S_CHECK:    state_in = (det_ff == '0) ? S_DONE : S_DIV;
         S_DIV: begin
            corner_in = '0;
            if (div_ctrl.done) state_in = S_ACC_RD;
         end
         S_ACC_RD:   state_in = S_ACC_WR;
         S_ACC_WR: begin
            corner_in = corner_ff + 1'b1;
            state_in  = (corner_ff == 2'd2) ? S_DONE : S_ACC_RD;
         end
         S_DONE:     if (rsp_free) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // Memory strobes and handshake outputs.
   always_comb begin
      req_tready = (state_ff == S_IDLE);
      vtx_we     = 1'b0;
      vtx_waddr  = AW'(idx_ff[0]);
      vtx_re     = 1'b0;
      vtx_raddr  = AW'(idx_ff[0]);
      sum_we     = 1'b0;
      sum_waddr  = AW'(idx_ff[0]);
      sum_wdata  = '0;
      sum_re     = 1'b0;
      sum_raddr  = AW'(idx_ff[0]);
      rsp_load   = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            sum_we    = 1'b1;
            sum_waddr = clr_cnt_ff;
         end
         S_LOAD: begin
            vtx_we = a_ok_ff;
            sum_we = a_ok_ff;
         end
         S_RD_ISSUE: sum_re = 1'b1;
         S_V0:       vtx_re = 1'b1;
         S_V1: begin
            vtx_re    = 1'b1;
            vtx_raddr = AW'(idx_ff[1]);
         end
         S_V2: begin
            vtx_re    = 1'b1;
            vtx_raddr = AW'(idx_ff[2]);
         end
         S_ACC_RD: begin
            sum_re    = 1'b1;
            sum_raddr = corner_addr;
         end
         S_ACC_WR: begin
            sum_we    = 1'b1;
            sum_waddr = corner_addr;
            sum_wdata = {sat_add(sum_rd_data[3*SUM_W-1:2*SUM_W], t_ff[2]),
                         sat_add(sum_rd_data[2*SUM_W-1:SUM_W], t_ff[1]),
                         sat_add(sum_rd_data[SUM_W-1:0], t_ff[0])};
         end
         S_DONE:     rsp_load = rsp_free;
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         corner_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         corner_ff    <= corner_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_tuser;
         idx_ff[0] <= in_first;
         idx_ff[1] <= in_second;
         idx_ff[2] <= in_third;
         a_ok_ff   <= in_range(in_first);
         // Vertex word holds x, y, z, u, v from the low bits up, as on the bus.
         load_ff   <= req_tdata[189:30];
         res_sums_ff <= '0;
         if (req_tuser == OP_LOAD) begin
            res_status_ff <= ST_LOADED;
         end else if (req_tuser == OP_TRIANGLE) begin
            res_status_ff <= ST_SKIPPED;
         end else begin
            res_status_ff <= ST_READ;
         end
      end
      if (state_ff == S_RD_CAPT && a_ok_ff) begin
         res_sums_ff <= sum_rd_data;
      end
      if (state_ff == S_V1) va_ff <= vtx_rd_data;
      if (state_ff == S_V2) vb_ff <= vtx_rd_data;
      if (state_ff == S_V3) vc_ff <= vtx_rd_data;
      if (state_ff == S_DELTA) begin
         du1_ff <= diff33(vb_ff[127:96], va_ff[127:96]);
         dv1_ff <= diff33(vb_ff[159:128], va_ff[159:128]);
         du2_ff <= diff33(vc_ff[127:96], va_ff[127:96]);
         dv2_ff <= diff33(vc_ff[159:128], va_ff[159:128]);
         for (int k = 0; k < 3; k++) begin
            e1_ff[k] <= diff33(vb_ff[k*COORD_W +: COORD_W], va_ff[k*COORD_W +: COORD_W]);
            e2_ff[k] <= diff33(vc_ff[k*COORD_W +: COORD_W], va_ff[k*COORD_W +: COORD_W]);
         end
      end
      if (state_ff == S_MUL) begin
         pdet_a_ff <= PROD_W'($signed(du1_ff) * $signed(dv2_ff));
         pdet_b_ff <= PROD_W'($signed(du2_ff) * $signed(dv1_ff));
         for (int k = 0; k < 3; k++) begin
            pn_a_ff[k] <= PROD_W'($signed(dv2_ff) * $signed(e1_ff[k]));
            pn_b_ff[k] <= PROD_W'($signed(dv1_ff) * $signed(e2_ff[k]));
         end
      end
      if (state_ff == S_DIFF) begin
         det_ff <= {pdet_a_ff[PROD_W-1], pdet_a_ff} - {pdet_b_ff[PROD_W-1], pdet_b_ff};
         for (int k = 0; k < 3; k++) begin
            num_ff[k] <= {pn_a_ff[k][PROD_W-1], pn_a_ff[k]}
                       - {pn_b_ff[k][PROD_W-1], pn_b_ff[k]};
         end
      end
      if (state_ff == S_DIV && div_ctrl.done) begin
         for (int k = 0; k < 3; k++) begin
            t_ff[k] <= quot[k];
         end
         res_status_ff <= ST_ADDED;
      end
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_sums_ff   <= res_sums_ff;
      end
   end

   tta_ram #(
      .WIDTH (VERTEX_W),
      .DEPTH (VERTEX_COUNT)
   ) u_vertex_ram (
      .clock   (clock),
      .wr_en   (vtx_we),
      .wr_addr (vtx_waddr),
      .wr_data (load_ff),
      .rd_en   (vtx_re),
      .rd_addr (vtx_raddr),
      .rd_data (vtx_rd_data)
   );

   tta_ram #(
      .WIDTH (SUMS_W),
      .DEPTH (VERTEX_COUNT)
   ) u_sum_ram (
      .clock   (clock),
      .wr_en   (sum_we),
      .wr_addr (sum_waddr),
      .wr_data (sum_wdata),
      .rd_en   (sum_re),
      .rd_addr (sum_raddr),
      .rd_data (sum_rd_data)
   );

   for (genvar k = 0; k < 3; k++) begin : g_div
      tta_div #(
         .FRACTION_BITS (FRACTION_BITS)
      ) u_div (
         .clock    (clock),
         .reset    (reset),
         .start    (div_ctrl.start),
         .num      (num_ff[k]),
         .den      (det_ff),
         .done     (div_done[k]),
         .quotient (quot[k])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_sums_ff;
   assign rsp_tuser  = rsp_status_ff;

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("second beat taken while an item is in flight");

   a_div_lanes_agree: assert property (@(posedge clock) disable iff (reset)
      (div_done != 3'b000) |-> (div_done == 3'b111))
      else $error("divider lanes out of step");

   a_clear_writes_zero: assert property (@(posedge clock) disable iff (reset)
      (sum_we && state_ff != S_ACC_WR) |-> (sum_wdata == '0))
      else $error("nonzero sum written outside accumulate");

   a_add_only_nonzero_det: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACC_RD) |-> (det_ff != '0 && op_ff == OP_TRIANGLE))
      else $error("accumulate without a valid triangle");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import tta_pkg::*;

   localparam logic [1:0] OP_READ     = 2'd2;
   localparam logic [1:0] OP_READ_ALT = 2'd3;
   localparam int NVERT = 1024;
   localparam logic signed [127:0] QUOT_MAX = (128'sd1 <<< 47) - 128'sd1;
   localparam logic signed [127:0] QUOT_MIN = -(128'sd1 <<< 47);
   localparam logic signed [48:0] SUM_HI = (49'sd1 <<< 47) - 49'sd1;
   localparam logic signed [48:0] SUM_LO = -(49'sd1 <<< 47);

   typedef struct {
      logic [1:0]         op;
      logic [9:0]         a, b, c;
      logic signed [31:0] px, py, pz, u, v;
   } vertex_cmd_t;

   typedef struct {
      logic [1:0]         status;
      logic signed [47:0] tx, ty, tz;
   } tangent_rsp_t;

   typedef struct {
      vertex_cmd_t  cmd;
      bit           typed;
      tangent_rsp_t want;
   } directed_row_t;

   logic clock, reset;
   logic req_tvalid, req_tready, rsp_tvalid, rsp_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [1:0] req_tuser, rsp_tuser;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   triangle_tangent_accumulator_core dut (.*);

   // Predictor state.
   logic signed [31:0] pos_x_mem [NVERT], pos_y_mem [NVERT], pos_z_mem [NVERT];
   logic signed [31:0] tex_u_mem [NVERT], tex_v_mem [NVERT];
   logic signed [47:0] sum_x_mem [NVERT], sum_y_mem [NVERT], sum_z_mem [NVERT];
   bit   written [NVERT];
   int   written_list [$];

   tangent_rsp_t pending_rsp [$];
   directed_row_t directed [$];
   int errors = 0, sent = 0, n_loaded = 0, n_added = 0, n_skipped = 0, n_read = 0;
   bit calm = 0, hold_done = 0;
   int hold_cycles = 0;

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d results outstanding", pending_rsp.size());
      $display("TEST FAILED");
      $finish;
   end

   function automatic logic signed [127:0] widen(input logic signed [31:0] x);
      return x;
   endfunction

   function automatic logic signed [47:0] tangent_quot(input logic signed [127:0] num,
                                                       input logic signed [127:0] den);
      logic signed [127:0] q;
      q = (num <<< 16) / den;
      if (q > QUOT_MAX) return QUOT_MAX[47:0];
      if (q < QUOT_MIN) return QUOT_MIN[47:0];
      return q[47:0];
   endfunction

   function automatic logic signed [47:0] sat_sum(input logic signed [47:0] s,
                                                  input logic signed [47:0] t);
      logic signed [48:0] r;
      r = s + t;
      if (r > SUM_HI) return SUM_HI[47:0];
      if (r < SUM_LO) return SUM_LO[47:0];
      return r[47:0];
   endfunction

   function automatic tangent_rsp_t predict_tangent(input vertex_cmd_t cm);
      tangent_rsp_t r;
      logic signed [127:0] du1, dv1, du2, dv2, det, num;
      logic signed [47:0] t [3];
      int corner [3];
      r = '{ST_LOADED, '0, '0, '0};
      if (cm.op == OP_LOAD) begin
         pos_x_mem[cm.a] = cm.px; pos_y_mem[cm.a] = cm.py; pos_z_mem[cm.a] = cm.pz;
         tex_u_mem[cm.a] = cm.u;  tex_v_mem[cm.a] = cm.v;
         sum_x_mem[cm.a] = '0; sum_y_mem[cm.a] = '0; sum_z_mem[cm.a] = '0;
         if (!written[cm.a]) begin
            written[cm.a] = 1;
            written_list.insert(written_list.size(), int'(cm.a));
         end
      end else if (cm.op == OP_TRIANGLE) begin
         du1 = widen(tex_u_mem[cm.b]) - widen(tex_u_mem[cm.a]);
         dv1 = widen(tex_v_mem[cm.b]) - widen(tex_v_mem[cm.a]);
         du2 = widen(tex_u_mem[cm.c]) - widen(tex_u_mem[cm.a]);
         dv2 = widen(tex_v_mem[cm.c]) - widen(tex_v_mem[cm.a]);
         det = du1 * dv2 - du2 * dv1;
         if (det == 0) begin
            r.status = ST_SKIPPED;
         end else begin
            num = dv2 * (widen(pos_x_mem[cm.b]) - widen(pos_x_mem[cm.a]))
                - dv1 * (widen(pos_x_mem[cm.c]) - widen(pos_x_mem[cm.a]));
            t[0] = tangent_quot(num, det);
            num = dv2 * (widen(pos_y_mem[cm.b]) - widen(pos_y_mem[cm.a]))
                - dv1 * (widen(pos_y_mem[cm.c]) - widen(pos_y_mem[cm.a]));
            t[1] = tangent_quot(num, det);
            num = dv2 * (widen(pos_z_mem[cm.b]) - widen(pos_z_mem[cm.a]))
                - dv1 * (widen(pos_z_mem[cm.c]) - widen(pos_z_mem[cm.a]));
            t[2] = tangent_quot(num, det);
            corner = '{int'(cm.a), int'(cm.b), int'(cm.c)};
            foreach (corner[k]) begin
               sum_x_mem[corner[k]] = sat_sum(sum_x_mem[corner[k]], t[0]);
               sum_y_mem[corner[k]] = sat_sum(sum_y_mem[corner[k]], t[1]);
               sum_z_mem[corner[k]] = sat_sum(sum_z_mem[corner[k]], t[2]);
            end
            r.status = ST_ADDED;
         end
      end else begin
         r = '{ST_READ, sum_x_mem[cm.a], sum_y_mem[cm.a], sum_z_mem[cm.a]};
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [47:0] got,
                                  input logic [47:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // Drives one beat and waits for it to be taken; the prediction is made on acceptance.
   task automatic send_beat(input vertex_cmd_t cm, input bit typed, input tangent_rsp_t want);
      tangent_rsp_t p;
      if (!calm && $urandom_range(99) < 18) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= cm.op;
      req_tdata  <= {2'b00, cm.v, cm.u, cm.pz, cm.py, cm.px, cm.c, cm.b, cm.a};
      do @(posedge clock); while (!req_tready);
      p = predict_tangent(cm);
      pending_rsp.insert(pending_rsp.size(), typed ? want : p);
      sent++;
      calm = (sent >= 400 && sent < 600);
   endtask

   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(9))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2, 3, 4: return $urandom();
         default: return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
      endcase
   endfunction

   function automatic int pick_written();
      return written_list[$urandom_range(0, written_list.size() - 1)];
   endfunction

   function automatic directed_row_t row(input logic [1:0] op, input int a, b, c,
                                         input logic signed [31:0] px, py, pz, u, v,
                                         input bit typed, input logic [1:0] st);
      row.cmd = '{op, 10'(a), 10'(b), 10'(c), px, py, pz, u, v};
      row.typed = typed;
      row.want = '{st, '0, '0, '0};
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if (!hold_done && sent == 900) begin
            hold_done = 1;
            hold_cycles = 600;
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= calm || $urandom_range(99) >= 18;
         end
      end
   end

   always @(posedge clock) begin
      tangent_rsp_t w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            $display("unexpected result beat, status %0d at %0t", rsp_tuser, $realtime);
            errors++;
         end else begin
            w = pending_rsp.pop_front();
            if (rsp_tuser !== w.status)
               report_mismatch("status", 48'(rsp_tuser), 48'(w.status));
            if (rsp_tdata[47:0] !== w.tx) report_mismatch("tangent_x", rsp_tdata[47:0], w.tx);
            if (rsp_tdata[95:48] !== w.ty) report_mismatch("tangent_y", rsp_tdata[95:48], w.ty);
            if (rsp_tdata[143:96] !== w.tz)
               report_mismatch("tangent_z", rsp_tdata[143:96], w.tz);
            case (rsp_tuser)
               ST_LOADED:  n_loaded++;
               ST_ADDED:   n_added++;
               ST_SKIPPED: n_skipped++;
               default:    n_read++;
            endcase
         end
      end
   end

   initial begin
      vertex_cmd_t cm;
      tangent_rsp_t none;
      int pick;
      none = '{ST_LOADED, '0, '0, '0};
      // Tangent sums start at zero after reset, loaded or not.
      foreach (sum_x_mem[i]) begin
         sum_x_mem[i] = '0;
         sum_y_mem[i] = '0;
         sum_z_mem[i] = '0;
      end
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      req_tuser = OP_LOAD;
      // Empty reads, a unit triangle, extremes, a saturating triangle and repeated corners.
      directed.push_front(row(OP_READ, 5, 0, 0, 0, 0, 0, 0, 0, 1, ST_READ));
      directed.insert(directed.size(),
                      row(OP_READ_ALT, 1023, 1023, 1023, -1, -1, -1, -1, -1, 1, ST_READ));
      directed.insert(directed.size(), row(OP_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 1, ST_LOADED));
      directed.insert(directed.size(),
                      row(OP_LOAD, 1, 0, 0, 32'h10000, 0, 0, 32'h10000, 0, 1, ST_LOADED));
      directed.insert(directed.size(),
                      row(OP_LOAD, 2, 0, 0, 0, 32'h10000, 0, 0, 32'h10000, 1, ST_LOADED));
      directed.insert(directed.size(), row(OP_TRIANGLE, 0, 1, 2, 0, 0, 0, 0, 0, 1, ST_ADDED));
      directed.insert(directed.size(), row(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, ST_READ));
      directed.insert(directed.size(), row(OP_READ_ALT, 2, 0, 0, 0, 0, 0, 0, 0, 0, ST_READ));
      directed.insert(directed.size(),
                      row(OP_LOAD, 6, 0, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
                          1, 0, 1, ST_LOADED));
      directed.insert(directed.size(),
                      row(OP_LOAD, 7, 0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                          0, 1, 1, ST_LOADED));
      directed.insert(directed.size(), row(OP_TRIANGLE, 0, 6, 7, 0, 0, 0, 0, 0, 1, ST_ADDED));
      directed.insert(directed.size(), row(OP_TRIANGLE, 0, 6, 7, 0, 0, 0, 0, 0, 1, ST_ADDED));
      directed.insert(directed.size(), row(OP_READ, 6, 0, 0, 0, 0, 0, 0, 0, 0, ST_READ));
      directed.insert(directed.size(), row(OP_READ, 7, 0, 0, 0, 0, 0, 0, 0, 0, ST_READ));
      directed.insert(directed.size(),
                      row(OP_TRIANGLE, 0, 0, 1, 0, 0, 0, 0, 0, 1, ST_SKIPPED));
      directed.insert(directed.size(),
                      row(OP_TRIANGLE, 1, 2, 2, 0, 0, 0, 0, 0, 1, ST_SKIPPED));
      directed.insert(directed.size(),
                      row(OP_LOAD, 3, 0, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                          32'sh8000_0000, 32'sh7FFF_FFFF, 1, ST_LOADED));
      directed.insert(directed.size(),
                      row(OP_LOAD, 1023, 1023, 1023, 32'sh8000_0000, 32'sh8000_0000,
                          32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 1, ST_LOADED));
      directed.insert(directed.size(),
                      row(OP_LOAD, 4, 0, 0, -1, 5, -7, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                          1, ST_LOADED));
      directed.insert(directed.size(),
                      row(OP_TRIANGLE, 3, 1023, 4, 0, 0, 0, 0, 0, 0, ST_ADDED));
      directed.insert(directed.size(),
                      row(OP_TRIANGLE, 1023, 4, 3, 0, 0, 0, 0, 0, 0, ST_ADDED));
      directed.insert(directed.size(), row(OP_READ, 1023, 0, 0, 0, 0, 0, 0, 0, 0, ST_READ));
      directed.insert(directed.size(), row(OP_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 1, ST_LOADED));
      directed.insert(directed.size(), row(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1, ST_READ));

      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (directed[i]) send_beat(directed[i].cmd, directed[i].typed, directed[i].want);

      repeat (1650) begin
         cm = '{OP_LOAD, 10'($urandom()), 10'($urandom()), 10'($urandom()), rand_coord(),
                rand_coord(), rand_coord(), rand_coord(), rand_coord()};
         pick = $urandom_range(99);
         if (pick < 30) begin
            // Most loads land in a small pool so triangles keep piling onto shared sums.
            if ($urandom_range(3) != 0) cm.a = 10'($urandom_range(0, 47));
         end else if (pick < 72) begin
            cm.op = OP_TRIANGLE;
            cm.a = 10'(pick_written());
            cm.b = 10'(pick_written());
            cm.c = 10'(pick_written());
            if ($urandom_range(19) == 0) cm.c = cm.a;
         end else begin
            cm.op = $urandom_range(1) ? OP_READ : OP_READ_ALT;
            if ($urandom_range(3) != 0) cm.a = 10'(pick_written());
         end
         send_beat(cm, 0, none);
      end
      req_tvalid <= 0;

      wait (pending_rsp.size() == 0);
      repeat (200) @(posedge clock);
      $display("covered %0d beats: %0d loads, %0d triangles added, %0d skipped, %0d reads",
               sent, n_loaded, n_added, n_skipped, n_read);
      $display("including extreme coordinates, saturated sums and a long result stall");
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches", errors);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
